// ===== hdl/tcp_option_order_matcher_top_macros.svh =====
// Assertion macros used by the matcher top-level RTL.
`ifndef TCP_OPTION_ORDER_MATCHER_TOP_MACROS_SVH
`define TCP_OPTION_ORDER_MATCHER_TOP_MACROS_SVH

`ifndef SYNTH
`define TOOM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("matcher assertion failed");
`define TOOM_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("matcher forbidden condition seen");
`else
`define TOOM_ASSERT(lbl, prop)
`define TOOM_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ===== hdl/tcpoom_pkg.sv =====
package tcpoom_pkg;

  localparam int NUM_SLOTS = 22;
  localparam int SLOT_W    = 3;
  localparam int LIST_W    = 64;
  localparam int SLOT_BITS = SLOT_W * NUM_SLOTS;
  localparam int EXT_W     = (SLOT_BITS > LIST_W) ? SLOT_BITS : LIST_W;
  localparam int POS_W     = $clog2(NUM_SLOTS);
  localparam int NUM_CODES = 4;
  localparam int CFG_IDX_W = 8;
  localparam int GRADE_W   = 2;

  localparam logic [EXT_W-1:0] EXT_MASK = {EXT_W{1'b1}} >> (EXT_W - SLOT_BITS);

  localparam logic [CFG_IDX_W-1:0] CFG_MSS       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SACK      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMESTAMP = 8'd3;

  localparam logic [GRADE_W-1:0] GRADE_CONFLICT = 2'd0;
  localparam logic [GRADE_W-1:0] GRADE_COMPAT   = 2'd1;
  localparam logic [GRADE_W-1:0] GRADE_IDENT    = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef slot_t [NUM_CODES-1:0] code_set_t;
  typedef logic [EXT_W-1:0] list_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } lookup_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [GRADE_W-1:0] grade;
  } walk_status_t;

  function automatic list_t ext_list(input logic [LIST_W-1:0] v);
    list_t e;
    e = EXT_W'(v);
    return e & EXT_MASK;
  endfunction

endpackage

// ===== hdl/tcpoom_cfg.sv =====
module tcpoom_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [tcpoom_pkg::CFG_IDX_W-1:0]   wr_index,
  input  tcpoom_pkg::slot_t                  wr_data,
  output tcpoom_pkg::code_set_t              codes
);

  tcpoom_pkg::code_set_t codes_r;
  tcpoom_pkg::code_set_t codes_nxt;

  always_comb begin
    codes_nxt = codes_r;
    if (wr_en) begin
      case (wr_index)
        tcpoom_pkg::CFG_MSS:       codes_nxt[0] = wr_data;
        tcpoom_pkg::CFG_WINDOW:    codes_nxt[1] = wr_data;
        tcpoom_pkg::CFG_SACK:      codes_nxt[2] = wr_data;
        tcpoom_pkg::CFG_TIMESTAMP: codes_nxt[3] = wr_data;
        default:                   codes_nxt = codes_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r[0] <= 3'd1;
      codes_r[1] <= 3'd2;
      codes_r[2] <= 3'd3;
      codes_r[3] <= 3'd4;
    end else begin
      codes_r <= codes_nxt;
    end
  end

  assign codes = codes_r;

endmodule

// ===== hdl/tcpoom_sig_table.sv =====
module tcpoom_sig_table (
  input  logic                  clk,
  input  logic                  load,
  input  tcpoom_pkg::list_t     sig_in,
  input  tcpoom_pkg::slot_t     code,
  output tcpoom_pkg::lookup_t   result
);

  tcpoom_pkg::slot_t [tcpoom_pkg::NUM_SLOTS-1:0] slots_r;
  logic [tcpoom_pkg::NUM_SLOTS-1:0]              alive_r;
  logic [tcpoom_pkg::NUM_SLOTS-1:0]              alive_nxt;

  // A slot is searchable only while some signature bit at or above it is set.
  always_comb begin
    for (int p = 0; p < tcpoom_pkg::NUM_SLOTS; p++) begin
      alive_nxt[p] = |(sig_in >> (p * tcpoom_pkg::SLOT_W));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int p = 0; p < tcpoom_pkg::NUM_SLOTS; p++) begin
        slots_r[p] <= sig_in[p*tcpoom_pkg::SLOT_W +: tcpoom_pkg::SLOT_W];
      end
      alive_r <= alive_nxt;
    end
  end

  always_comb begin
    result = '0;
    for (int p = tcpoom_pkg::NUM_SLOTS - 1; p >= 0; p--) begin
      if (alive_r[p] && (slots_r[p] == code)) begin
        result.found = 1'b1;
        result.pos   = tcpoom_pkg::POS_W'(p);
      end
    end
  end

endmodule

// ===== hdl/tcpoom_walker.sv =====
module tcpoom_walker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  tcpoom_pkg::list_t         tgt_in,
  input  logic                      eq_in,
  input  tcpoom_pkg::code_set_t     codes,
  input  tcpoom_pkg::lookup_t       lookup,
  input  logic                      res_free,
  output tcpoom_pkg::slot_t         code,
  output tcpoom_pkg::walk_status_t  status
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                          state_r, state_nxt;
  tcpoom_pkg::list_t             tgt_r, tgt_nxt;
  logic                          eq_r, eq_nxt;
  logic [tcpoom_pkg::POS_W-1:0]  last_r, last_nxt;
  logic                          have_last_r, have_last_nxt;
  logic                          important;
  logic                          fin;
  logic [tcpoom_pkg::GRADE_W-1:0] grade;

  assign code = tgt_r[tcpoom_pkg::SLOT_W-1:0];

  always_comb begin
    important = 1'b0;
    for (int i = 0; i < tcpoom_pkg::NUM_CODES; i++) begin
      if (codes[i] == code) important = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    tgt_nxt       = tgt_r;
    eq_nxt        = eq_r;
    last_nxt      = last_r;
    have_last_nxt = have_last_r;
    fin           = 1'b0;
    grade         = tcpoom_pkg::GRADE_COMPAT;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          tgt_nxt       = tgt_in;
          eq_nxt        = eq_in;
          have_last_nxt = 1'b0;
          state_nxt     = ST_RUN;
        end
      end
      ST_RUN: begin
        if (eq_r) begin
          fin   = 1'b1;
          grade = tcpoom_pkg::GRADE_IDENT;
        end else if (tgt_r == '0) begin
          fin = 1'b1;
        end else if (important && lookup.found && have_last_r && (lookup.pos < last_r)) begin
          fin   = 1'b1;
          grade = tcpoom_pkg::GRADE_CONFLICT;
        end else begin
          tgt_nxt = tgt_r >> tcpoom_pkg::SLOT_W;
          if (important && lookup.found) begin
            last_nxt      = lookup.pos;
            have_last_nxt = 1'b1;
          end
        end
        if (fin && res_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_last_r <= have_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r  <= tgt_nxt;
    eq_r   <= eq_nxt;
    last_r <= last_nxt;
  end

  assign status.busy  = (state_r == ST_RUN);
  assign status.done  = fin && res_free;
  assign status.grade = grade;

endmodule

// ===== hdl/tcp_option_order_matcher_top.sv =====
// Timing: an accepted item loads the walker; identical lists finish at once, otherwise the
// walker first steps past k target slots (0 to 22), and the result is then registered.
// A new item is accepted only once the walker is idle; the walker takes one 3-bit slot a cycle.
// A finished walk waits in the walker while the held result register waits for out_tready.
// Reset: option codes return to 1, 2, 3 and 4, the walker idles, and no result is pending.
`include "tcp_option_order_matcher_top_macros.svh"

module tcp_option_order_matcher_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: target_list[63:0], signature_list[127:64].
  input  logic [127:0]                      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: match_grade[1:0], zero fill [7:2].
  output logic [7:0]                        out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcpoom_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcpoom_pkg::SLOT_W-1:0]     cfg_data
);

  tcpoom_pkg::code_set_t          codes;
  tcpoom_pkg::list_t              tgt_ext;
  tcpoom_pkg::list_t              sig_ext;
  tcpoom_pkg::lookup_t            lookup;
  tcpoom_pkg::slot_t              code;
  tcpoom_pkg::walk_status_t       status;
  logic                           start;
  logic                           res_free;
  logic                           out_valid_r, out_valid_nxt;
  logic [tcpoom_pkg::GRADE_W-1:0] out_grade_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !status.busy;
  assign start     = in_tvalid && in_tready;
  assign res_free  = !out_valid_r || out_tready;
  assign tgt_ext   = tcpoom_pkg::ext_list(in_tdata[63:0]);
  assign sig_ext   = tcpoom_pkg::ext_list(in_tdata[127:64]);

  tcpoom_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .codes    (codes)
  );

  tcpoom_sig_table u_sig (
    .clk    (clk),
    .load   (start),
    .sig_in (sig_ext),
    .code   (code),
    .result (lookup)
  );

  tcpoom_walker u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .tgt_in   (tgt_ext),
    .eq_in    (tgt_ext == sig_ext),
    .codes    (codes),
    .lookup   (lookup),
    .res_free (res_free),
    .code     (code),
    .status   (status)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (status.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      out_grade_r <= status.grade;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_grade_r};

  `TOOM_ASSERT(a_one_item_at_a_time, in_tvalid && in_tready |=> !in_tready)
  `TOOM_ASSERT(a_done_needs_room, status.done |-> (!out_valid_r || out_tready))
  `TOOM_ASSERT(a_grade_legal, out_valid_r |-> (out_grade_r <= tcpoom_pkg::GRADE_IDENT))
  `TOOM_ASSERT_NEVER(a_no_start_while_busy, start && status.busy)

endmodule
